// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the scharr gradient rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/sgm_pkg.sv =====
// shared types, constants and arithmetic helpers of the scharr gradient block
`timescale 1ns / 1ps

package sgm_pkg;

  // frame geometry
  localparam int MAX_WIDTH    = 1024;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = 12;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 12;
  localparam int MIN_DIM      = 3;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd480;

  // pixel and gray
  localparam int PIX_W      = 8;
  localparam int GRAY_W     = 7;
  localparam int CSUM_W     = 10;
  localparam int GRAY_PROD_W = 18;
  // floor(s/10) == (s*205) >> 11 for every s up to 3*255
  localparam logic [GRAY_PROD_W-1:0] GRAY_RECIP = 18'd205;
  localparam int GRAY_SHIFT = 11;

  // kernel and magnitude
  localparam int SUM_W  = 12;
  localparam int SQ_W   = 2 * SUM_W;
  localparam int ROOT_IN_W = 16;
  localparam logic [SUM_W-1:0] W_SIDE = 12'd9;
  localparam logic [SUM_W-1:0] W_MID  = 12'd15;
  localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;
  localparam logic [SQ_W:0] SAT_LIMIT = 25'd65025;

  // square root pipeline
  localparam int SQRT_STEPS      = 8;
  localparam int SQRT_STAGES     = 4;
  localparam int SQ_STATE_W      = 17;

  // front to back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one classified pixel
  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic [PIX_W-1:0]  alpha;
    logic [COL_W-1:0]  x;
    logic [ROW_W-1:0]  y;
    logic              emit;
    logic              last;
  } qent_t;

  // fields that travel alongside the arithmetic
  typedef struct packed {
    logic [PIX_W-1:0] center_alpha;
    logic [COL_W-1:0] center_x;
    logic [ROW_W-1:0] center_y;
    logic             frame_last;
  } meta_t;

  // remainder and partial root of the digit-by-digit square root
  typedef struct packed {
    logic [SQ_STATE_W-1:0] rem;
    logic [SQ_STATE_W-1:0] root;
  } sq_t;

  function automatic logic [GRAY_W-1:0] gray_of(input logic [PIX_W-1:0] r,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] b);
    logic [CSUM_W-1:0]      s;
    logic [GRAY_PROD_W-1:0] p;
    s = CSUM_W'(r) + CSUM_W'(g) + CSUM_W'(b);
    p = GRAY_PROD_W'(s) * GRAY_RECIP;
    return p[GRAY_SHIFT +: GRAY_W];
  endfunction

  function automatic logic [SUM_W-1:0] kernel_sum(input logic [GRAY_W-1:0] a,
                                                 input logic [GRAY_W-1:0] m,
                                                 input logic [GRAY_W-1:0] c);
    return SUM_W'(a) * W_SIDE + SUM_W'(m) * W_MID + SUM_W'(c) * W_SIDE;
  endfunction

  function automatic sq_t sqrt_step(input sq_t s, input logic [SQ_STATE_W-1:0] bitv);
    logic [SQ_STATE_W-1:0] trial;
    sq_t o;
    trial = s.root + bitv;
    if (s.rem >= trial) begin
      o.rem  = s.rem - trial;
      o.root = (s.root >> 1) + bitv;
    end else begin
      o.rem  = s.rem;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

endpackage

// ===== hw/rtl/sgm_if.sv =====
// valid/ready channel interfaces for pixels in and gradient results out
`timescale 1ns / 1ps

interface sgm_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface sgm_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  magnitude;
  logic [7:0]  center_alpha;
  logic [9:0]  center_x;
  logic [11:0] center_y;
  logic        frame_last;

  modport source (output valid, magnitude, center_alpha, center_x, center_y, frame_last,
                  input ready);
  modport sink (input valid, magnitude, center_alpha, center_x, center_y, frame_last,
                output ready);
endinterface

// ===== hw/rtl/sgm_queue.sv =====
// short fifo between the classifying front and the arithmetic back
`timescale 1ns / 1ps

module sgm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sgm_pkg::qent_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sgm_pkg::qent_t out_data
);
  import sgm_pkg::*;

  qent_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  // handshake on both sides
  assign in_ready  = count != QCNT_W'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_data;
  end

endmodule

// ===== hw/rtl/sgm_front.sv =====
// pixel intake: gray conversion, frame position and border classification
`timescale 1ns / 1ps

module sgm_front (
  input  logic                               clk,
  input  logic                               rst,
  sgm_pixel_if.sink                          pixel_in,
  input  logic                               cfg_we,
  input  logic [sgm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sgm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               q_valid,
  input  logic                               q_ready,
  output sgm_pkg::qent_t                     q_data
);
  import sgm_pkg::*;

  localparam int ROW_EXT_W = ROW_W + 1;

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [COL_W-1:0]        column_count;
  logic [ROW_W-1:0]        row_count;
  logic [WIDTH_REG_W-1:0]  w_used;
  logic [HEIGHT_REG_W-1:0] h_used;
  logic                    col_end;
  logic                    row_end;
  logic                    accept;

  // clamp the programmed frame size to the supported range
  always_comb begin
    if (image_width < WIDTH_REG_W'(MIN_DIM)) w_used = WIDTH_REG_W'(MIN_DIM);
    else if (image_width > WIDTH_REG_W'(MAX_WIDTH)) w_used = WIDTH_REG_W'(MAX_WIDTH);
    else w_used = image_width;
    if (image_height < HEIGHT_REG_W'(MIN_DIM)) h_used = HEIGHT_REG_W'(MIN_DIM);
    else h_used = image_height;
  end

  // position flags
  assign col_end = (WIDTH_REG_W'(column_count) + WIDTH_REG_W'(1)) >= w_used;
  assign row_end = (ROW_EXT_W'(row_count) + ROW_EXT_W'(1)) >= ROW_EXT_W'(h_used);

  // handshake
  assign pixel_in.ready = q_ready;
  assign q_valid        = pixel_in.valid;
  assign accept         = pixel_in.valid && q_ready;

  // classified entry
  always_comb begin
    q_data.gray  = gray_of(pixel_in.red, pixel_in.green, pixel_in.blue);
    q_data.alpha = pixel_in.alpha;
    q_data.x     = column_count;
    q_data.y     = row_count;
    q_data.emit  = (column_count >= COL_W'(2)) && (row_count >= ROW_W'(2));
    q_data.last  = col_end && row_end;
  end

  // config registers and raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_IMAGE_WIDTH: begin
          image_width  <= cfg_data[WIDTH_REG_W-1:0];
          column_count <= '0;
          row_count    <= '0;
        end
        CFG_IMAGE_HEIGHT: begin
          image_height <= cfg_data[HEIGHT_REG_W-1:0];
          column_count <= '0;
          row_count    <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (col_end) begin
        column_count <= '0;
        if (row_end) row_count <= '0;
        else row_count <= row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/sgm_isqrt.sv =====
// pipelined saturating integer square root, two result bits per stage
`timescale 1ns / 1ps

module sgm_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [sgm_pkg::ROOT_IN_W-1:0] in_value,
  input  logic                         in_sat,
  input  sgm_pkg::meta_t               in_meta,
  output logic                         out_valid,
  output logic [sgm_pkg::PIX_W-1:0]    out_mag,
  output sgm_pkg::meta_t               out_meta
);
  import sgm_pkg::*;

  localparam int STEPS_PER_STAGE = SQRT_STEPS / SQRT_STAGES;

  logic  st_valid [SQRT_STAGES];
  sq_t   st_val   [SQRT_STAGES];
  logic  st_sat   [SQRT_STAGES];
  meta_t st_meta  [SQRT_STAGES];
  sq_t   in_val;

  assign in_val.rem  = SQ_STATE_W'(in_value);
  assign in_val.root = '0;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [SQ_STATE_W-1:0] BIT_HI =
      SQ_STATE_W'(1) << (2 * (SQRT_STEPS - 1 - STEPS_PER_STAGE * k));
    localparam logic [SQ_STATE_W-1:0] BIT_LO =
      SQ_STATE_W'(1) << (2 * (SQRT_STEPS - 2 - STEPS_PER_STAGE * k));

    sq_t   src;
    logic  src_valid;
    logic  src_sat;
    meta_t src_meta;

    if (k == 0) begin : g_first
      assign src       = in_val;
      assign src_valid = in_valid;
      assign src_sat   = in_sat;
      assign src_meta  = in_meta;
    end else begin : g_next
      assign src       = st_val[k-1];
      assign src_valid = st_valid[k-1];
      assign src_sat   = st_sat[k-1];
      assign src_meta  = st_meta[k-1];
    end

    // stage valid
    always_ff @(posedge clk) begin
      if (rst) st_valid[k] <= 1'b0;
      else if (en) st_valid[k] <= src_valid;
    end

    // two root digits
    always_ff @(posedge clk) begin
      if (en) begin
        st_val[k]  <= sqrt_step(sqrt_step(src, BIT_HI), BIT_LO);
        st_sat[k]  <= src_sat;
        st_meta[k] <= src_meta;
      end
    end
  end

  // saturate on the way out
  assign out_valid = st_valid[SQRT_STAGES-1];
  assign out_mag   = st_sat[SQRT_STAGES-1] ? MAG_MAX : st_val[SQRT_STAGES-1].root[PIX_W-1:0];
  assign out_meta  = st_meta[SQRT_STAGES-1];

endmodule

// ===== hw/rtl/sgm_back.sv =====
// line buffers, 3x3 window, scharr sums, magnitude and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sgm_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  sgm_pkg::qent_t q_data,
  sgm_result_if.source   result_out
);
  import sgm_pkg::*;

  // whole pipeline moves when the result register is free
  logic adv;
  logic pop;

  // line buffers
  logic [GRAY_W-1:0] lb_top [MAX_WIDTH];
  logic [GRAY_W-1:0] lb_mid [MAX_WIDTH];
  logic [PIX_W-1:0]  lb_alpha [MAX_WIDTH];
  logic [GRAY_W-1:0] rd_top;
  logic [GRAY_W-1:0] rd_mid;
  logic [PIX_W-1:0]  rd_alpha;

  // read stage
  logic  s1_valid;
  qent_t s1;

  // window stage
  logic [8:0][GRAY_W-1:0] win;
  logic [PIX_W-1:0]       alpha_delay;
  logic                   s2_valid;
  meta_t                  s2_meta;
  logic [SUM_W-1:0]       left;
  logic [SUM_W-1:0]       right;
  logic [SUM_W-1:0]       upper;
  logic [SUM_W-1:0]       lower;
  logic signed [SUM_W:0]  sx;
  logic signed [SUM_W:0]  sy;

  // abs, square and sum stages
  logic             s3_valid;
  meta_t            s3_meta;
  logic [SUM_W-1:0] ax;
  logic [SUM_W-1:0] ay;
  logic             s4_valid;
  meta_t            s4_meta;
  logic [SQ_W-1:0]  sq_x;
  logic [SQ_W-1:0]  sq_y;
  logic [SQ_W:0]    sq_sum;
  logic             s5_valid;
  meta_t            s5_meta;
  logic [ROOT_IN_W-1:0] s5_value;
  logic             s5_sat;

  // root and result
  logic             rt_valid;
  logic [PIX_W-1:0] rt_mag;
  meta_t            rt_meta;
  logic             out_valid;
  logic [PIX_W-1:0] out_mag;
  meta_t            out_meta;

  assign adv     = !out_valid || result_out.ready;
  assign q_ready = adv;
  assign pop     = adv && q_valid;

  // top row buffer, refilled from the middle row value held by the read stage
  always_ff @(posedge clk) begin
    if (pop) rd_top <= lb_top[q_data.x];
    if (adv && s1_valid) lb_top[s1.x] <= rd_mid;
  end

  // middle row buffer
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_mid <= lb_mid[q_data.x];
      lb_mid[q_data.x] <= q_data.gray;
    end
  end

  // alpha row buffer
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_alpha <= lb_alpha[q_data.x];
      lb_alpha[q_data.x] <= q_data.alpha;
    end
  end

  // read stage register
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (adv) s1_valid <= q_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) s1 <= q_data;
  end

  // window shift and alpha delay
  always_ff @(posedge clk) begin
    if (rst) begin
      win         <= '0;
      alpha_delay <= '0;
      s2_valid    <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1.emit;
      if (s1_valid) begin
        for (int r = 0; r < 3; r++) begin
          win[r*3]     <= win[r*3 + 1];
          win[r*3 + 1] <= win[r*3 + 2];
        end
        win[2]      <= rd_top;
        win[5]      <= rd_mid;
        win[8]      <= s1.gray;
        alpha_delay <= rd_alpha;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_meta.center_alpha <= alpha_delay;
      s2_meta.center_x     <= s1.x - COL_W'(1);
      s2_meta.center_y     <= s1.y - ROW_W'(1);
      s2_meta.frame_last   <= s1.last;
    end
  end

  // scharr sums over the window
  always_comb begin
    left  = kernel_sum(win[0], win[3], win[6]);
    right = kernel_sum(win[2], win[5], win[8]);
    upper = kernel_sum(win[0], win[1], win[2]);
    lower = kernel_sum(win[6], win[7], win[8]);
    sx    = $signed({1'b0, left}) - $signed({1'b0, right});
    sy    = $signed({1'b0, upper}) - $signed({1'b0, lower});
  end

  // absolute gradients
  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (adv) s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_meta <= s2_meta;
      ax      <= sx[SUM_W] ? SUM_W'(-sx) : sx[SUM_W-1:0];
      ay      <= sy[SUM_W] ? SUM_W'(-sy) : sy[SUM_W-1:0];
    end
  end

  // squares
  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else if (adv) s4_valid <= s3_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_meta <= s3_meta;
      sq_x    <= SQ_W'(ax) * SQ_W'(ax);
      sq_y    <= SQ_W'(ay) * SQ_W'(ay);
    end
  end

  // sum of squares and saturation check
  assign sq_sum = (SQ_W + 1)'(sq_x) + (SQ_W + 1)'(sq_y);

  always_ff @(posedge clk) begin
    if (rst) s5_valid <= 1'b0;
    else if (adv) s5_valid <= s4_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_meta  <= s4_meta;
      s5_value <= sq_sum[ROOT_IN_W-1:0];
      s5_sat   <= sq_sum >= SAT_LIMIT;
    end
  end

  sgm_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s5_valid),
    .in_value  (s5_value),
    .in_sat    (s5_sat),
    .in_meta   (s5_meta),
    .out_valid (rt_valid),
    .out_mag   (rt_mag),
    .out_meta  (rt_meta)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= rt_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_mag  <= rt_mag;
      out_meta <= rt_meta;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.magnitude    = out_mag;
  assign result_out.center_alpha = out_meta.center_alpha;
  assign result_out.center_x     = out_meta.center_x;
  assign result_out.center_y     = out_meta.center_y;
  assign result_out.frame_last   = out_meta.frame_last;

  // checks
  `ASSERT_NEXT(a_win_hold, clk, rst, !adv, $stable(win))
  `ASSERT_NEXT(a_alpha_hold, clk, rst, !adv, $stable(alpha_delay))
  `ASSERT_NEXT(a_pop_reads, clk, rst, pop, s1_valid)
  `ASSERT_IMPLY(a_center_inner, clk, rst, out_valid, (out_meta.center_x != '0) && (out_meta.center_y != '0))

endmodule

// ===== hw/rtl/scharr_gradient_magnitude.sv =====
// top level of the scharr gradient magnitude block
// usage:
//   pixel_in carries rgba pixels in raster order, one transaction per pixel,
//   accepted when valid and ready are both high. result_out carries one
//   transaction per interior pixel of the frame: the saturated magnitude, the
//   centre alpha and coordinates, and frame_last on the final interior pixel.
//   border pixels give no transaction.
//   cfg_we/cfg_index/cfg_data write image_width (index 0) or image_height
//   (index 1) while the block is idle; a write restarts the frame.
//   the pixel that completes a window passes the queue, line buffer read,
//   window, abs, square, sum, four root stages and result register before
//   its result leaves. throughput is one pixel per cycle while result_out is
//   ready, set by the line buffers, each read once and written once per pixel.
//   when result_out stalls, the back pipeline holds; the four-entry queue
//   keeps accepting pixels until it fills, then pixel_in.ready drops.
//   reset (rst, synchronous) clears the counters, window, queue and pipeline
//   and loads width 640 and height 480; line buffer contents stay undefined
//   until written, which no result depends on.
`timescale 1ns / 1ps

module scharr_gradient_magnitude (
  input  logic                            clk,
  input  logic                            rst,
  sgm_pixel_if.sink                       pixel_in,
  sgm_result_if.source                    result_out,
  input  logic                            cfg_we,
  input  logic [sgm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sgm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sgm_pkg::*;

  logic  f_valid;
  logic  f_ready;
  qent_t f_data;
  logic  b_valid;
  logic  b_ready;
  qent_t b_data;

  // intake and classification
  sgm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pixel_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_data    (f_data)
  );

  // decoupling queue
  sgm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  // window and magnitude pipeline
  sgm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_data     (b_data),
    .result_out (result_out)
  );

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the scharr gradient magnitude block: random and directed frames, self-checked
`timescale 1ns / 1ps

module tb;
  import sgm_pkg::*;

  // timing of the run
  localparam int IDLE_PCT      = 29;
  localparam int DRAIN_CYCLES  = 32;
  localparam int TOTAL_PIXELS  = 1300;
  localparam int RUN_LIMIT_NS  = 5_000_000;

  // arithmetic of the gradient
  localparam int SIDE_WEIGHT  = 9;
  localparam int MID_WEIGHT   = 15;
  localparam int GRAY_DIVISOR = 10;
  localparam int MAG_LIMIT    = 255;

  // spare register indexes that the block ignores
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  // one gradient result as the block reports it
  typedef struct packed {
    logic [7:0]  magnitude;
    logic [7:0]  alpha;
    logic [9:0]  x;
    logic [11:0] y;
    logic        last;
  } grad_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  bit                     idle_on = 1'b1;
  int unsigned            pixels_sent;
  int unsigned            mismatch_count;

  // predicted frame state
  logic [6:0]  upper_row [MAX_WIDTH];
  logic [6:0]  middle_row [MAX_WIDTH];
  logic [7:0]  alpha_row [MAX_WIDTH];
  logic [6:0]  gray_win [3][3];
  logic [7:0]  alpha_hold;
  int unsigned col_cnt;
  int unsigned row_cnt;
  int unsigned width_reg;
  int unsigned height_reg;
  grad_t       pending_grads[$];

  sgm_pixel_if  pixel_ch ();
  sgm_result_if result_ch ();

  scharr_gradient_magnitude DUT (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pixel_ch),
    .result_out(result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // weighted sum of one kernel line
  function automatic int weighted_line(input logic [6:0] a, input logic [6:0] m,
                                       input logic [6:0] c);
    return SIDE_WEIGHT * int'(a) + MID_WEIGHT * int'(m) + SIDE_WEIGHT * int'(c);
  endfunction

  // floor of the square root, saturated
  function automatic logic [7:0] sat_root(input int unsigned v);
    int unsigned root;
    int unsigned trial;
    int          b;
    if (v >= MAG_LIMIT * MAG_LIMIT) return 8'(MAG_LIMIT);
    root = 0;
    for (b = 7; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= v) root = trial;
    end
    return 8'(root);
  endfunction

  // advance the frame state by one pixel and queue the gradient it completes
  task automatic predict_gradient(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b, input logic [7:0] a);
    int unsigned w, h, x, y, sq;
    int          sx, sy, i;
    logic [6:0]  gray, top, mid;
    logic [7:0]  prev_alpha;
    grad_t       item;
    w = (width_reg < MIN_DIM) ? MIN_DIM : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
    x = col_cnt % MAX_WIDTH;
    y = row_cnt;
    gray = 7'((int'(r) + int'(g) + int'(b)) / GRAY_DIVISOR);
    top = upper_row[x];
    mid = middle_row[x];
    prev_alpha = alpha_hold;
    // shift the window and refill its right column
    for (i = 0; i < 3; i++) begin
      gray_win[i][0] = gray_win[i][1];
      gray_win[i][1] = gray_win[i][2];
    end
    gray_win[0][2] = top;
    gray_win[1][2] = mid;
    gray_win[2][2] = gray;
    upper_row[x] = mid;
    middle_row[x] = gray;
    alpha_hold = alpha_row[x];
    alpha_row[x] = a;
    // interior centre gives a result
    if (x >= 2 && y >= 2) begin
      sx = weighted_line(gray_win[0][0], gray_win[1][0], gray_win[2][0])
         - weighted_line(gray_win[0][2], gray_win[1][2], gray_win[2][2]);
      sy = weighted_line(gray_win[0][0], gray_win[0][1], gray_win[0][2])
         - weighted_line(gray_win[2][0], gray_win[2][1], gray_win[2][2]);
      sq = sx * sx + sy * sy;
      item.magnitude = sat_root(sq);
      item.alpha = prev_alpha;
      item.x = 10'(x - 1);
      item.y = 12'(y - 1);
      item.last = (x + 1 >= w) && (y + 1 >= h);
      pending_grads.push_back(item);
    end
    // raster counters
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
  endtask

  // track register writes and accepted pixels
  always @(posedge clk) begin : track_frame
    int i, j;
    if (rst) begin
      for (i = 0; i < MAX_WIDTH; i++) begin
        upper_row[i] = '0;
        middle_row[i] = '0;
        alpha_row[i] = '0;
      end
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) gray_win[i][j] = '0;
      end
      alpha_hold = '0;
      col_cnt = 0;
      row_cnt = 0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IMAGE_WIDTH) begin
          width_reg = cfg_data[WIDTH_REG_W-1:0];
          col_cnt = 0;
          row_cnt = 0;
        end else if (cfg_index == CFG_IMAGE_HEIGHT) begin
          height_reg = cfg_data[HEIGHT_REG_W-1:0];
          col_cnt = 0;
          row_cnt = 0;
        end
      end
      if (pixel_ch.valid && pixel_ch.ready) begin
        predict_gradient(pixel_ch.red, pixel_ch.green, pixel_ch.blue, pixel_ch.alpha);
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_gradients
    grad_t got, want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = {result_ch.magnitude, result_ch.center_alpha, result_ch.center_x,
             result_ch.center_y, result_ch.frame_last};
      if (pending_grads.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected result: mag %0d alpha %0d x %0d y %0d last %0b",
                   got.magnitude, got.alpha, got.x, got.y, got.last);
        end
        mismatch_count++;
      end else begin
        want = pending_grads.pop_front();
        if (got !== want) begin
          if (mismatch_count < 10) begin
            $display("mismatch at x %0d y %0d: expected mag %0d alpha %0d x %0d y %0d last %0b",
                     want.x, want.y, want.magnitude, want.alpha, want.x, want.y, want.last);
            $display("  actual mag %0d alpha %0d x %0d y %0d last %0b",
                     got.magnitude, got.alpha, got.x, got.y, got.last);
          end
          mismatch_count++;
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rst || !idle_on) result_ch.ready <= 1'b1;
    else result_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
  end

  // one pixel transaction
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] a);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      pixel_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.red <= r;
    pixel_ch.green <= g;
    pixel_ch.blue <= b;
    pixel_ch.alpha <= a;
    @(posedge clk);
    while (pixel_ch.ready !== 1'b1) @(posedge clk);
    pixels_sent++;
  endtask

  // random pixels around one base level
  task automatic send_pixels(input int unsigned count, input int unsigned spread);
    int unsigned base, i;
    base = $urandom_range(255 - spread);
    for (i = 0; i < count; i++) begin
      send_pixel(8'(base + $urandom_range(spread)), 8'(base + $urandom_range(spread)),
                 8'(base + $urandom_range(spread)), 8'($urandom));
    end
  endtask

  // flat, smooth, textured or noisy content
  function automatic int unsigned random_spread();
    case ($urandom_range(3))
      0: return 0;
      1: return 6;
      2: return 30;
      default: return 255;
    endcase
  endfunction

  // register write, after which cfg_we is low again before the task returns
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // drain every outstanding result and let border pixels leave the pipeline
  task automatic wait_idle();
    pixel_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_grads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // reset geometry: 640 wide, the first two rows give no results
  task automatic test_default_geometry();
    send_pixels(640 + 10, random_spread());
  endtask

  // smallest frame: strong vertical edge, then a faint horizontal one in the next frame
  task automatic test_directed_frames();
    int row, col;
    bit centre;
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 12'd3);
    write_reg(CFG_IMAGE_HEIGHT, 12'd3);
    for (row = 0; row < 3; row++) begin
      for (col = 0; col < 3; col++) begin
        centre = (row == 1 && col == 1);
        if (col == 0) send_pixel(8'd255, 8'd255, 8'd255, centre ? 8'd255 : 8'd0);
        else send_pixel(8'd0, 8'd0, 8'd0, centre ? 8'd255 : 8'd0);
      end
    end
    for (row = 0; row < 3; row++) begin
      for (col = 0; col < 3; col++) begin
        centre = (row == 1 && col == 1);
        if (row == 0) send_pixel(8'd3, 8'd3, 8'd4, centre ? 8'd0 : 8'd255);
        else send_pixel(8'd9, 8'd0, 8'd0, centre ? 8'd0 : 8'd255);
      end
    end
  endtask

  // out-of-range and masked register values
  task automatic test_register_saturation();
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 12'hFFF);
    write_reg(CFG_IMAGE_HEIGHT, 12'h000);
    send_pixels(30, random_spread());
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 12'h801);
    write_reg(CFG_IMAGE_HEIGHT, 12'h002);
    send_pixels(18, random_spread());
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 12'h000);
    send_pixels(9, random_spread());
  endtask

  // writes to unused indexes leave the frame position alone
  task automatic test_spare_indexes();
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 12'd5);
    write_reg(CFG_IMAGE_HEIGHT, 12'd4);
    send_pixels(7, random_spread());
    wait_idle();
    write_reg(CFG_SPARE_2, 12'hABC);
    write_reg(CFG_SPARE_3, 12'h543);
    send_pixels(33, random_spread());
  endtask

  // a write mid-frame restarts the frame
  task automatic test_frame_restart();
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 12'd6);
    write_reg(CFG_IMAGE_HEIGHT, 12'd5);
    send_pixels(15, random_spread());
    wait_idle();
    write_reg(CFG_IMAGE_HEIGHT, 12'd5);
    send_pixels(30, random_spread());
  endtask

  // start of the tallest frame, streamed with no idling on either side
  task automatic test_tall_frame();
    wait_idle();
    idle_on = 1'b0;
    write_reg(CFG_IMAGE_WIDTH, 12'd3);
    write_reg(CFG_IMAGE_HEIGHT, 12'hFFF);
    send_pixels(3 * 64, random_spread());
    wait_idle();
    idle_on = 1'b1;
  endtask

  // random small geometries, whole, doubled or cut-short frames
  task automatic test_random_frames();
    int unsigned w, h, n;
    while (pixels_sent < TOTAL_PIXELS) begin
      w = ($urandom_range(4) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 3);
      h = $urandom_range(8, 3);
      wait_idle();
      write_reg(CFG_IMAGE_WIDTH, 12'(w));
      write_reg(CFG_IMAGE_HEIGHT, 12'(h));
      case ($urandom_range(3))
        0: n = $urandom_range(w * h - 1, 1);
        1: n = 2 * w * h;
        default: n = w * h;
      endcase
      if (n > TOTAL_PIXELS - pixels_sent) n = TOTAL_PIXELS - pixels_sent;
      send_pixels(n, random_spread());
    end
  endtask

  // main sequence
  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    pixel_ch.valid <= 1'b0;
    pixel_ch.red <= '0;
    pixel_ch.green <= '0;
    pixel_ch.blue <= '0;
    pixel_ch.alpha <= '0;
    pixels_sent = 0;
    mismatch_count = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_default_geometry();
    test_directed_frames();
    test_register_saturation();
    test_spare_indexes();
    test_frame_restart();
    test_tall_frame();
    test_random_frames();
    wait_idle();
    if (mismatch_count == 0 && pending_grads.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard limit on the run
  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d results outstanding", pending_grads.size());
    $display("simulation failed");
    $finish;
  end

endmodule
